// ----- sv/swst_pkg.sv -----
// Shared widths and defaults for the sliding window statistics block.
// No dependencies; imported by every module of the block.
package swst_pkg;

  localparam int SAMPLE_W          = 32;
  localparam int ENTRY_W           = 33;
  localparam int SUM_OUT_W         = 39;
  localparam int DEF_WINDOW_DEPTH  = 64;

endpackage

// ----- sv/swst_cell.sv -----
// One storage cell of the window chain: holds a single entry.
// Depends on swst_pkg for the entry width.
module swst_cell
  import swst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic signed [ENTRY_W-1:0] d,
  output logic signed [ENTRY_W-1:0] q
);

  logic signed [ENTRY_W-1:0] q_r;

  // entry takes its neighbour's value whenever the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ----- sv/swst_div.sv -----
// Floor division of the window sum by the window depth, done as a multiply
// by a constant reciprocal, 16 bits of the reciprocal per cycle.
// Depends on swst_pkg.
module swst_div
  import swst_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SUM_W        = SUM_OUT_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  output logic                      done,
  output logic signed [ENTRY_W-1:0] quotient
);

  // magnitude stays below 2^MAG_W; the reciprocal is exact for that range
  localparam int RW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int MAG_W = SUM_W - 1;
  localparam int SH    = MAG_W + RW;
  localparam int M_W   = MAG_W + 1;
  localparam int CH    = 16;
  localparam int NCH   = (M_W + CH - 1) / CH;
  localparam int ACC_W = MAG_W + CH;
  localparam int QS    = SH - CH * (NCH - 1);
  localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [CH*NCH-1:0] RECIP_C = (CH * NCH)'(RECIP_64);
  localparam logic [SUM_W-1:0]  BIAS_C  = SUM_W'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0]     LAST_C  = CW'(NCH - 1);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [MAG_W-1:0]  mag_r;
  logic [CH*NCH-1:0] recip_r;
  logic [ACC_W-1:0]  acc_r;
  logic [CW-1:0]     cnt_r;

  logic [SUM_W-1:0]   mag;
  logic [ACC_W-1:0]   part;
  logic [ACC_W-1:0]   q_full;
  logic [ENTRY_W-1:0] q_mag;

  // floor for a negative sum: -( (|s| + depth - 1) / depth )
  assign mag = dividend[SUM_W-1] ? (BIAS_C - $unsigned(dividend)) : $unsigned(dividend);

  // magnitude times one 16-bit slice of the reciprocal
  assign part = ACC_W'(mag_r) * ACC_W'(recip_r[CH-1:0]);

  // sequencing: one reciprocal slice per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_C) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: low product bits are final once shifted out, so drop them
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r   <= dividend[SUM_W-1];
      mag_r   <= mag[MAG_W-1:0];
      recip_r <= RECIP_C;
      acc_r   <= '0;
    end else if (busy_r) begin
      acc_r   <= (acc_r >> CH) + part;
      recip_r <= recip_r >> CH;
    end
  end

  assign q_full   = acc_r >> QS;
  assign q_mag    = q_full[ENTRY_W-1:0];
  assign quotient = neg_r ? -$signed(q_mag) : $signed(q_mag);
  assign done     = done_r;

endmodule

// ----- sv/sliding_window_stats.sv -----
// Sliding window statistics: sum, floor average, maximum and minimum over
// the last WINDOW_DEPTH entries of a 32-bit sample stream.
// Depends on swst_pkg, swst_cell and swst_div.
//
// - Input channel in_valid/in_stall/in_sample: one sample per request. In
//   delta mode (cfg_wdata written through cfg_we) the stored entry is the
//   sample minus the previous sample taken in delta mode.
// - Output channel out_valid/out_stall: exactly one result per sample,
//   held in an output register until the receiver drops out_stall.
// - out_valid rises after the full rotation of the cell chain past the single
//   min/max comparator; the reciprocal average multiply runs alongside it.
// - One sample is in work at a time: in_stall is high from acceptance until
//   the result moves into the output register, so a new request is not taken
//   before then. A new sample may be taken while the previous result still
//   waits on out_stall.
// - Receiver stall: the finished result waits inside the block until the
//   output register is free; nothing is dropped.
// - Synchronous reset clears every entry, the sum, previous sample and mode.
module sliding_window_stats
  import swst_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [SAMPLE_W-1:0]         in_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ENTRY_W-1:0]   out_newest_entry,
  output logic signed [SUM_OUT_W-1:0] out_window_sum,
  output logic signed [ENTRY_W-1:0]   out_window_avg,
  output logic signed [ENTRY_W-1:0]   out_window_max,
  output logic signed [ENTRY_W-1:0]   out_window_min
);

  localparam int GROW_W = ENTRY_W + $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = (GROW_W > SUM_OUT_W) ? GROW_W : SUM_OUT_W;
  localparam int CW     = $clog2(WINDOW_DEPTH);
  localparam logic [CW-1:0] ROT_LAST_C = CW'(WINDOW_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                    state_r;
  logic                      delta_mode_r;
  logic [SAMPLE_W-1:0]       prev_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [ENTRY_W-1:0] new_r;
  logic signed [ENTRY_W-1:0] max_r;
  logic signed [ENTRY_W-1:0] min_r;
  logic [CW-1:0]             rot_r;

  logic                      out_valid_r;
  logic signed [ENTRY_W-1:0] out_new_r;
  logic signed [SUM_OUT_W-1:0] out_sum_r;
  logic signed [ENTRY_W-1:0] out_avg_r;
  logic signed [ENTRY_W-1:0] out_max_r;
  logic signed [ENTRY_W-1:0] out_min_r;

  logic                      in_acc;
  logic                      out_free;
  logic                      out_load;
  logic                      chain_en;
  logic signed [ENTRY_W-1:0] entry;
  logic signed [ENTRY_W-1:0] tail;
  logic                      div_start;
  logic                      div_done;
  logic signed [ENTRY_W-1:0] div_q;

  logic signed [ENTRY_W-1:0] cell_d [WINDOW_DEPTH];
  logic signed [ENTRY_W-1:0] cell_q [WINDOW_DEPTH];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FIN) && div_done && out_free;

  // new entry: raw sample or difference from the previous one
  assign entry = delta_mode_r ? ($signed({1'b0, in_sample}) - $signed({1'b0, prev_r}))
                              : $signed({1'b0, in_sample});
  assign tail  = cell_q[WINDOW_DEPTH-1];

  // running sum drops the entry that falls off the end
  assign sum_nxt = sum_r - SUM_W'(tail) + SUM_W'(entry);

  // chain of cells: shift on a request, rotate tail to head while scanning
  assign chain_en  = in_acc || (state_r == ST_RUN);
  assign cell_d[0] = (state_r == ST_IDLE) ? entry : tail;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end
    swst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (chain_en),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  // average divider starts on the first scan cycle, once sum_r is updated
  assign div_start = (state_r == ST_RUN) && (rot_r == '0);

  swst_div #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration and per-request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b0;
      prev_r       <= '0;
      sum_r        <= '0;
    end else begin
      if (cfg_we) begin
        delta_mode_r <= cfg_wdata;
      end
      if (in_acc) begin
        sum_r <= sum_nxt;
        if (delta_mode_r) begin
          prev_r <= in_sample;
        end
      end
    end
  end

  // sequencer, min/max scan and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output valid: set on a load, cleared once the result is taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          rot_r <= '0;
          if (in_acc) begin
            new_r   <= entry;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (rot_r == '0 || tail > max_r) begin
            max_r <= tail;
          end
          if (rot_r == '0 || tail < min_r) begin
            min_r <= tail;
          end
          if (rot_r == ROT_LAST_C) begin
            rot_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            rot_r <= rot_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_new_r   <= new_r;
            out_sum_r   <= sum_r[SUM_OUT_W-1:0];
            out_avg_r   <= div_q;
            out_max_r   <= max_r;
            out_min_r   <= min_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_newest_entry = out_new_r;
  assign out_window_sum   = out_sum_r;
  assign out_window_avg   = out_avg_r;
  assign out_window_max   = out_max_r;
  assign out_window_min   = out_min_r;

`ifndef SYNTHESIS
  // a request always starts a full scan
  a_acc_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) && (rot_r == '0))
    else $error("request did not start a scan");

  // scan counter is parked outside the scan
  a_rot_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (rot_r == '0))
    else $error("rotation counter not parked");

  // a new result is only loaded from the finishing state with the divider done
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && div_done && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded on completion");

  // minimum never exceeds maximum in a delivered result
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_min_r <= out_max_r))
    else $error("window minimum above maximum");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for sliding_window_stats: directed and random
// samples in direct and delta mode, with random gaps and back-pressure.
// Depends on swst_pkg and the sliding_window_stats RTL.
module testbench
  import swst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEF_WINDOW_DEPTH;
  // generous drain allowance at the end of the test
  localparam int SETTLE = 2 * (DEPTH + 42);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 94;

  localparam logic [SAMPLE_W-1:0] PLAIN_SAMPLES [10] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0000
  };
  localparam logic [SAMPLE_W-1:0] DELTA_SAMPLES [11] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003,
    32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h1234_5678
  };

  typedef struct {
    logic signed [ENTRY_W-1:0]   newest;
    logic signed [SUM_OUT_W-1:0] sum;
    logic signed [ENTRY_W-1:0]   avg;
    logic signed [ENTRY_W-1:0]   max;
    logic signed [ENTRY_W-1:0]   min;
  } window_stats_t;

  typedef enum int {RUN_COUNTER, RUN_WIDE, RUN_SMALL, RUN_EXTREME, RUN_HOLD} run_kind_t;

  // Mirror of the window: predicts the statistics for every accepted request
  // and checks results against them in order.
  class stats_tracker;
    longint          window [DEPTH];
    longint          running_sum;
    logic [SAMPLE_W-1:0] prev_sample;
    bit              delta_on;
    int              oldest;
    window_stats_t   awaited_stats [$];
    int              mismatches;
    int              samples_taken;
    int              stats_checked;

    function new();
      foreach (window[i]) window[i] = 0;
      running_sum = 0;
      prev_sample = '0;
      delta_on = 1'b0;
      oldest = 0;
      mismatches = 0;
      samples_taken = 0;
      stats_checked = 0;
    endfunction

    function void set_delta(bit on);
      delta_on = on;
    endfunction

    function window_stats_t predict_stats(logic [SAMPLE_W-1:0] s);
      longint entry;
      longint hi;
      longint lo;
      longint quot;
      window_stats_t r;
      // previous sample only moves while in delta mode
      if (delta_on) begin
        entry = longint'(s) - longint'(prev_sample);
        prev_sample = s;
      end else begin
        entry = longint'(s);
      end
      running_sum = running_sum - window[oldest] + entry;
      window[oldest] = entry;
      oldest = (oldest + 1) % DEPTH;
      hi = window[0];
      lo = window[0];
      for (int i = 1; i < DEPTH; i++) begin
        if (window[i] > hi) hi = window[i];
        if (window[i] < lo) lo = window[i];
      end
      // floor division, not truncation toward zero
      quot = running_sum / DEPTH;
      if ((running_sum % DEPTH) != 0 && running_sum < 0) quot = quot - 1;
      r.newest = entry[ENTRY_W-1:0];
      r.sum    = running_sum[SUM_OUT_W-1:0];
      r.avg    = quot[ENTRY_W-1:0];
      r.max    = hi[ENTRY_W-1:0];
      r.min    = lo[ENTRY_W-1:0];
      return r;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      window_stats_t next_stats;
      next_stats = predict_stats(s);
      awaited_stats.insert(awaited_stats.size(), next_stats);
      samples_taken++;
    endfunction

    function void note_mismatch(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
      mismatches++;
      $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
               $time, stats_checked, field, want, got);
    endfunction

    function void check_stats(window_stats_t got);
      window_stats_t want;
      if (awaited_stats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual sum %0d",
                 $time, got.sum);
        return;
      end
      want = awaited_stats.pop_front();
      if (got.newest !== want.newest) note_mismatch("newest_entry", want.newest, got.newest);
      if (got.sum !== want.sum) note_mismatch("window_sum", want.sum, got.sum);
      if (got.avg !== want.avg) note_mismatch("window_avg", want.avg, got.avg);
      if (got.max !== want.max) note_mismatch("window_max", want.max, got.max);
      if (got.min !== want.min) note_mismatch("window_min", want.min, got.min);
      stats_checked++;
    endfunction

    function int pending();
      return awaited_stats.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_stall;
  logic signed [ENTRY_W-1:0]   out_newest_entry;
  logic signed [SUM_OUT_W-1:0] out_window_sum;
  logic signed [ENTRY_W-1:0]   out_window_avg;
  logic signed [ENTRY_W-1:0]   out_window_max;
  logic signed [ENTRY_W-1:0]   out_window_min;

  stats_tracker tracker;
  int send_idle_pct;
  int stall_pct;
  int cycles;
  int mode_writes;
  logic [SAMPLE_W-1:0] counter_value;
  run_kind_t run_kind;
  int run_left;
  logic [SAMPLE_W-1:0] hold_value;

  sliding_window_stats #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_newest_entry (out_newest_entry),
    .out_window_sum   (out_window_sum),
    .out_window_avg   (out_window_avg),
    .out_window_max   (out_window_max),
    .out_window_min   (out_window_min)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, tracker.pending());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver back-pressure, with the odd long stall
  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= ($urandom_range(0, 49) == 0) ? $urandom_range(1, 100) : 0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // observe handshakes at the rising edge
  always @(posedge clk) begin
    window_stats_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.newest = out_newest_entry;
        got.sum    = out_window_sum;
        got.avg    = out_window_avg;
        got.max    = out_window_max;
        got.min    = out_window_min;
        tracker.check_stats(got);
      end
      if (in_valid && !in_stall) tracker.take_sample(in_sample);
    end
  end

  // one request; entered and left at a falling edge
  task send_sample(input logic [SAMPLE_W-1:0] s);
    if (send_idle_pct > 0 && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 80)) @(negedge clk);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait until every predicted result has been returned
  task drain();
    in_valid = 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  task write_delta_mode(input bit on);
    cfg_we = 1'b1;
    cfg_wdata = on;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_delta(on);
    mode_writes++;
  endtask

  // runs of related samples: counters (with wrap), holds that can fill the
  // window, extremes, small and fully random values
  function logic [SAMPLE_W-1:0] pick_sample();
    int roll;
    if (run_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) run_kind = RUN_COUNTER;
      else if (roll < 55) run_kind = RUN_WIDE;
      else if (roll < 70) run_kind = RUN_SMALL;
      else if (roll < 85) run_kind = RUN_EXTREME;
      else run_kind = RUN_HOLD;
      run_left = (run_kind == RUN_HOLD) ? $urandom_range(1, 80) : $urandom_range(1, 40);
      if (run_kind == RUN_COUNTER && $urandom_range(0, 3) == 0)
        counter_value = 32'hFFFF_F000 + $urandom_range(0, 4095);
      hold_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
    end
    run_left--;
    case (run_kind)
      RUN_COUNTER: begin
        counter_value = counter_value + $urandom_range(0, 2000);
        return counter_value;
      end
      RUN_WIDE:  return $urandom;
      RUN_SMALL: return $urandom_range(0, 255);
      RUN_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          4: return 32'h0000_0001;
          default: return 32'hFFFF_FFFE;
        endcase
      end
      default: return hold_value;
    endcase
  endfunction

  initial begin
    int send_pcts [4];
    int stall_pcts [4];
    send_pcts  = '{0, 56, 0, 34};
    stall_pcts = '{0, 0, 56, 34};
    tracker = new();
    mode_writes = 0;
    run_left = 0;
    run_kind = RUN_WIDE;
    counter_value = '0;
    hold_value = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes in direct mode
    write_delta_mode(1'b0);
    foreach (PLAIN_SAMPLES[i]) send_sample(PLAIN_SAMPLES[i]);
    drain();

    // directed: first delta from the untouched previous sample, largest
    // positive and negative deltas, negative sums for the floor average
    write_delta_mode(1'b1);
    foreach (DELTA_SAMPLES[i]) send_sample(DELTA_SAMPLES[i]);
    drain();

    // random phases: each idling pattern in both modes; the first delta
    // after a direct phase uses the previous sample kept from before
    for (int p = 0; p < 8; p++) begin
      send_idle_pct = send_pcts[p / 2];
      stall_pct = stall_pcts[p / 2];
      write_delta_mode(1'(p % 2));
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain();
    end

    stall_pct = 0;
    repeat (SETTLE) @(negedge clk);
    if (tracker.pending() > 0) begin
      tracker.mismatches += tracker.pending();
      $display("%0t: %0d results never arrived", $time, tracker.pending());
    end
    $display("summary: %0d samples sent, %0d results checked, %0d mode writes",
             tracker.samples_taken, tracker.stats_checked, mode_writes);
    $display("summary: direct and delta windows under four idling patterns, %0d mismatches",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/swst_pkg.sv
sv/swst_cell.sv
sv/swst_div.sv
sv/sliding_window_stats.sv
tb/sv/testbench.sv
